// ===== hw/rtl/tdpt_pkg.sv =====
// Shared definitions for the trial division prime test core.
// Holds the datapath width, the controller state type and the command and status structs.
// Depends on nothing.
package tdpt_pkg;

  localparam int NUM_WIDTH = 16;
  localparam int IN_WIDTH  = 16;
  localparam int SQ_WIDTH  = NUM_WIDTH + 2;
  localparam int CNT_WIDTH = $clog2(NUM_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EVAL,
    ST_FINISH
  } tdpt_state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic next_div;
    logic emit;
  } tdpt_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic sq_gt_n;
    logic cnt_zero;
    logic rem_zero;
    logic out_full;
  } tdpt_sts_t;

endpackage

// ===== hw/rtl/tdpt_ctrl.sv =====
// Controller of the trial division prime test core.
// Sequences the square check, the serial remainder and the result hand-off.
// Depends on tdpt_pkg.
module tdpt_ctrl import tdpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tdpt_sts_t sts_i,
  output tdpt_cmd_t cmd_o
);

  tdpt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.n_lt2 || sts_i.sq_gt_n) state_d = ST_FINISH;
        else                              state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.cnt_zero) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.rem_zero) state_d = ST_FINISH;
        else                state_d = ST_CHECK;
      end
      ST_FINISH: begin
        if (!sts_i.out_full) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.div_start = !(sts_i.n_lt2 || sts_i.sq_gt_n);
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_EVAL: begin
        cmd_o.next_div = !sts_i.rem_zero;
      end
      ST_FINISH: begin
        cmd_o.emit = !sts_i.out_full;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tdpt_dpath.sv =====
// Datapath of the trial division prime test core.
// Holds the number, divisor, running square, bit-serial remainder and the result register.
// Depends on tdpt_pkg.
module tdpt_dpath import tdpt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tdpt_cmd_t           cmd_i,
  output tdpt_sts_t           sts_o,
  input  logic [IN_WIDTH-1:0] number_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                is_prime_o
);

  logic [NUM_WIDTH-1:0] n_q, n_d;
  logic [NUM_WIDTH-1:0] div_q, div_d;
  logic [SQ_WIDTH-1:0]  sq_q, sq_d;
  logic [NUM_WIDTH-1:0] rem_q, rem_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                 valid_q, valid_d;
  logic                 prime_q, prime_d;

  logic [31:0]          num_wide;
  logic [NUM_WIDTH:0]   trial;
  logic [NUM_WIDTH:0]   trial_sub;

  assign num_wide  = 32'(number_i);
  assign trial     = {rem_q, n_q[cnt_q]};
  assign trial_sub = trial - {1'b0, div_q};

  assign sts_o.n_lt2    = (n_q < NUM_WIDTH'(2));
  assign sts_o.sq_gt_n  = (sq_q > {2'b00, n_q});
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.rem_zero = (rem_q == '0);
  assign sts_o.out_full = valid_q && out_stall_i;

  always_comb begin
    n_d     = n_q;
    div_d   = div_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    prime_d = prime_q;
    valid_d = valid_q && out_stall_i;
    if (cmd_i.load) begin
      n_d   = num_wide[NUM_WIDTH-1:0];
      div_d = NUM_WIDTH'(2);
      sq_d  = SQ_WIDTH'(4);
    end
    if (cmd_i.div_start) begin
      rem_d = '0;
      cnt_d = CNT_WIDTH'(NUM_WIDTH - 1);
    end
    if (cmd_i.div_step) begin
      if (trial >= {1'b0, div_q}) rem_d = trial_sub[NUM_WIDTH-1:0];
      else                        rem_d = trial[NUM_WIDTH-1:0];
      cnt_d = cnt_q - CNT_WIDTH'(1);
    end
    if (cmd_i.next_div) begin
      div_d = div_q + NUM_WIDTH'(1);
      sq_d  = sq_q + {1'b0, div_q, 1'b1};
    end
    if (cmd_i.emit) begin
      valid_d = 1'b1;
      prime_d = !sts_o.n_lt2 && sts_o.sq_gt_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    prime_q <= prime_d;
  end

  assign out_valid_o = valid_q;
  assign is_prime_o  = prime_q;

endmodule

// ===== hw/rtl/trial_division_prime_test_core.sv =====
// Top level of the trial division prime test core.
// Joins the controller and the datapath; depends on tdpt_pkg, tdpt_ctrl and tdpt_dpath.
//
//   channel | valid      | stall       | payload
//   input   | in_valid_i | in_stall_o  | number_i (16 bits, unsigned)
//   output  | out_valid_o| out_stall_i | is_prime_o (1 bit)
//
// After acceptance the words 0 and 1 go straight to the result; any other word runs the
// bit-serial remainder once per divisor tried, until the divisor's square exceeds the number
// or a remainder is zero (at most 254 divisors for 16 bits), then returns to idle for the next word.
// The bit-serial remainder loop produces one quotient bit a cycle.
// Reset is asynchronous and active low and clears the controller and the output valid.
// A new word is taken as soon as the search is idle, even while a result waits on stall.
module trial_division_prime_test_core import tdpt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [IN_WIDTH-1:0] number_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                is_prime_o
);

  tdpt_cmd_t cmd;
  tdpt_sts_t sts;

  tdpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tdpt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .number_i    (number_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_prime_o  (is_prime_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a search was still starting");

  a_emit_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !sts.out_full)
    else $error("result written over a pending word");

  a_div_only_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> (!sts.n_lt2 && !sts.sq_gt_n))
    else $error("division started past the square bound");
`endif

endmodule
